[src/rrb_pkg.sv]
// Shared types and constants for the newest-first row ring buffer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rrb_pkg;

  // Ring size in words. The address arithmetic wraps by masking, so this stays a power of two.
  localparam int BUFFER_WORDS = 1024;
  localparam int AW           = $clog2(BUFFER_WORDS);      // word address bits
  localparam int PW           = $clog2(BUFFER_WORDS + 1);  // pointer bits, holds BUFFER_WORDS
  localparam int MAX_ROW      = 64;
  localparam int NW           = $clog2(MAX_ROW) + 1;       // row length bits, holds MAX_ROW
  localparam int WIRW         = $clog2(MAX_ROW);           // word-in-row bits
  localparam int POSW         = 10;
  localparam int CFG_AW       = 3;
  localparam logic [CFG_AW-1:0] REG_FLOATS_PER_ROW = 3'd0;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_RECENT = 2'd1,
    MODE_INDEX  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_READ  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [31:0]     word_in;
    logic [POSW-1:0] row_position;
    logic            final_row;
  } in_req_t;

  typedef struct packed {
    logic [31:0]   word_out;
    logic [1:0]    status;
    logic          last;
    logic [PW-1:0] rows_stored;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic walk_en;
    logic read_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_walk;
    logic start_read;
    logic walk_last;
    logic read_last;
  } sts_t;

endpackage

`default_nettype wire

[src/row_ring_buffer_newest_first.sv]
// Top level of the newest-first row ring buffer: config block, controller and datapath.
// Depends on rrb_pkg, rrb_cfg, rrb_ctrl and rrb_dp.
`default_nettype none

// A ring of 1024 32-bit words holds rows of floats_per_row words (register at byte address 0,
// 1 to 64, low 7 bits stored; zero acts as one and values 65 to 127 as 64). A request is taken
// when start is high and busy is low. A write request stores one word and gives no result; a
// clear request resets all pointers. Status results (empty, already read, out of range) appear
// in the cycle after the request and do not raise busy. A recent-row read walks back
// row_position + 1 rows, one row per cycle, then streams the row out of the memory read port
// one word per cycle; an indexed read computes its start address at once and streams the row
// the same way. Both reads keep busy high until the last word of the row is issued. Each result
// is on out_res for exactly one cycle with out_strobe high, the first word in the cycle after
// its address is issued; the receiver cannot stall, so it must take every strobed result. The
// memory is not cleared by reset or by clear; reading a word that was never written returns
// an undefined value.
module row_ring_buffer_newest_first
  import rrb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request channel.
  input  wire logic              start,
  output logic                   busy,
  input  wire in_req_t           in_req,
  // Result channel.
  output logic                   out_strobe,
  output out_res_t               out_res,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [NW-1:0] floats_per_row;
  cmd_t          cmd;
  sts_t          sts;

  // The user must write the row length register only while the block is idle; the block does not enforce it.
  rrb_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .floats_per_row (floats_per_row)
  );

  // The controller decides how long a request occupies the block.
  rrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the ring, the pointers and the result register.
  rrb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req         (in_req),
    .floats_per_row (floats_per_row),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_res        (out_res)
  );

endmodule

`default_nettype wire

[src/rrb_cfg.sv]
// APB-style configuration register block holding the row length.
// Depends on rrb_pkg.
`default_nettype none

module rrb_cfg
  import rrb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [NW-1:0]     floats_per_row
);

  logic [NW-1:0] fpr_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpr_r <= NW'(1);
    end else if (psel && penable && pwrite && (paddr == REG_FLOATS_PER_ROW)) begin
      fpr_r <= pwdata[NW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FLOATS_PER_ROW) begin
      prdata = 32'(fpr_r);
    end
  end

  assign floats_per_row = fpr_r;

endmodule

`default_nettype wire

[src/rrb_ctrl.sv]
// Sequencing state machine: idle, backward row walk, and row readout.
// Depends on rrb_pkg.
`default_nettype none

module rrb_ctrl
  import rrb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.walk_en = 1'b0;
    cmd.read_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && sts.start_walk) begin
          state_nxt = ST_WALK;
        end else if (start && sts.start_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        if (sts.read_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_walk_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && sts.walk_last) |=> (state_r == ST_READ))
    else $error("walk did not hand over to readout");

  a_read_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && sts.read_last) |=> !busy)
    else $error("readout did not return to idle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.accept)
    else $error("request accepted while busy");

endmodule

`default_nettype wire

[src/rrb_dp.sv]
// Datapath: ring memory, write/anchor/count pointers, row address walk and result register.
// Depends on rrb_pkg; sequenced by rrb_ctrl.
`default_nettype none

module rrb_dp
  import rrb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  input  wire in_req_t       in_req,
  input  wire logic [NW-1:0] floats_per_row,
  output sts_t               sts,
  output logic               out_strobe,
  output out_res_t           out_res
);

  localparam int MW = PW + 1 + NW;    // width of the row-count room check
  localparam int SW = POSW + NW + 2;  // signed width of the indexed start address

  logic [31:0] mem [BUFFER_WORDS];

  logic [PW-1:0]   wp_r, tail_r, anchor_r, cnt_r;
  logic [WIRW-1:0] wir_r;
  logic [PW-1:0]   t_r;
  logic [POSW-1:0] steps_r;
  logic [AW-1:0]   base_r;
  logic [WIRW-1:0] k_r;
  logic [31:0]     rd_data_r;
  logic            out_valid_r, out_last_r, out_sel_r;
  logic [1:0]      out_status_r;

  logic [NW-1:0]   n;
  mode_t           mode;

  // Effective row length: zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (floats_per_row == '0) begin
      n = NW'(1);
    end else if (floats_per_row > NW'(MAX_ROW)) begin
      n = NW'(MAX_ROW);
    end else begin
      n = floats_per_row;
    end
  end

  assign mode = mode_t'(in_req.mode);

  // Write path.
  logic [PW-1:0] space, wp_base, wp_sat;
  logic [PW:0]   wp_sum;
  logic          wrap, row_end, cnt_inc;
  logic [NW-1:0] wir_inc;
  logic [AW-1:0] waddr;
  logic [MW-1:0] cnt_need;

  always_comb begin
    space    = PW'(BUFFER_WORDS) - wp_r;
    wrap     = (wir_r == '0) && (space < PW'(n));
    wp_base  = wrap ? '0 : wp_r;
    waddr    = AW'(wp_base + PW'(wir_r));
    wir_inc  = NW'(wir_r) + NW'(1);
    row_end  = (wir_inc >= n);
    wp_sum   = (PW + 1)'(wp_base) + (PW + 1)'(n);
    wp_sat   = (wp_sum > (PW + 1)'(BUFFER_WORDS)) ? PW'(BUFFER_WORDS) : wp_sum[PW-1:0];
    cnt_need = (MW'(cnt_r) + MW'(1)) * MW'(n);
    cnt_inc  = (cnt_need <= MW'(BUFFER_WORDS));
  end

  // Read checks and the indexed start address.
  logic          is_empty, already, oor, single;
  logic [1:0]    single_code;
  logic [PW-1:0] anchor_back, anchor_eff;
  logic [SW-1:0] pos_prod, diff, radj;

  always_comb begin
    is_empty    = (wp_r == '0);
    already     = (anchor_r == wp_r);
    oor         = (PW'(in_req.row_position) >= cnt_r);
    anchor_back = (wp_r >= PW'(n)) ? (wp_r - PW'(n)) : '0;
    anchor_eff  = (in_req.row_position == '0) ? anchor_back : anchor_r;
    pos_prod    = SW'(in_req.row_position) * SW'(n);
    diff        = SW'(anchor_eff) - pos_prod;
    radj        = diff[SW-1] ? (diff + SW'(PW'(BUFFER_WORDS) - tail_r)) : diff;
    single      = is_empty || ((mode == MODE_RECENT) && already) || oor;
    if (is_empty) begin
      single_code = STAT_EMPTY;
    end else if ((mode == MODE_RECENT) && already) begin
      single_code = STAT_READ;
    end else begin
      single_code = STAT_RANGE;
    end
  end

  // One backward step over the ring; a pointer at zero jumps past the unused tail first.
  logic [PW-1:0] t_cur, t_nxt;

  always_comb begin
    t_cur = (t_r == '0) ? (PW'(BUFFER_WORDS) - tail_r) : t_r;
    t_nxt = (t_cur >= PW'(n)) ? (t_cur - PW'(n)) : '0;
  end

  logic [AW-1:0] raddr;
  logic          k_last;

  assign raddr  = base_r + AW'(k_r);
  assign k_last = (k_r == WIRW'(n - NW'(1)));

  assign sts.start_walk = (mode == MODE_RECENT) && !single;
  assign sts.start_read = (mode == MODE_INDEX) && !single;
  assign sts.walk_last  = (steps_r == '0);
  assign sts.read_last  = k_last;

  logic accept_write, accept_single;
  assign accept_write  = cmd.accept && (mode == MODE_WRITE);
  assign accept_single = cmd.accept && ((mode == MODE_RECENT) || (mode == MODE_INDEX)) && single;

  // Pointer and counter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      tail_r      <= '0;
      anchor_r    <= '0;
      cnt_r       <= '0;
      wir_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept_single || cmd.read_en;
      if (cmd.accept) begin
        unique case (mode)
          MODE_WRITE: begin
            if (wrap) begin
              tail_r <= space;
            end
            if (row_end) begin
              wir_r <= '0;
              wp_r  <= wp_sat;
              if (cnt_inc) begin
                cnt_r <= cnt_r + PW'(1);
              end
            end else begin
              wir_r <= wir_inc[WIRW-1:0];
              wp_r  <= wp_base;
            end
          end
          MODE_CLEAR: begin
            wp_r     <= '0;
            tail_r   <= '0;
            anchor_r <= '0;
            cnt_r    <= '0;
            wir_r    <= '0;
          end
          MODE_RECENT: begin
            if (!single && in_req.final_row) begin
              anchor_r <= wp_r;
            end
          end
          MODE_INDEX: begin
            if (!is_empty && (in_req.row_position == '0)) begin
              anchor_r <= anchor_back;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Walk and readout working registers and the result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r          <= wp_r;
      steps_r      <= in_req.row_position;
      base_r       <= radj[AW-1:0];
      k_r          <= '0;
      out_status_r <= single_code;
      out_last_r   <= 1'b1;
      out_sel_r    <= 1'b0;
    end
    if (cmd.walk_en) begin
      t_r     <= t_nxt;
      steps_r <= steps_r - POSW'(1);
      if (sts.walk_last) begin
        base_r <= t_nxt[AW-1:0];
        k_r    <= '0;
      end
    end
    if (cmd.read_en) begin
      k_r          <= k_r + WIRW'(1);
      out_status_r <= STAT_OK;
      out_last_r   <= k_last;
      out_sel_r    <= 1'b1;
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept_write) begin
      mem[waddr] <= in_req.word_in;
    end
    if (cmd.read_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_strobe          = out_valid_r;
  assign out_res.word_out    = out_sel_r ? rd_data_r : 32'd0;
  assign out_res.status      = out_status_r;
  assign out_res.last        = out_last_r;
  assign out_res.rows_stored = cnt_r;

  a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_en |=> (out_valid_r && out_sel_r))
    else $error("row read issued without a result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept_single |=> (out_valid_r && out_last_r && !out_sel_r))
    else $error("status result not marked last");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PW'(BUFFER_WORDS))
    else $error("write pointer beyond ring");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_en |-> (NW'(k_r) < n))
    else $error("readout index beyond row length");

endmodule

`default_nettype wire
